// ===== hw/rtl/matrix_multiply_engine_assert.svh =====
// assertion macros for the matrix multiply engine
// used by files that check their own control logic; no other dependencies
`ifndef MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define MME_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mme implication check failed");

// next-cycle implication, disabled while reset is high
`define MME_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mme next-cycle check failed");

`endif

// ===== hw/rtl/mme_pkg.sv =====
// shared types and constants of the matrix multiply engine
// no dependencies
`timescale 1ns / 1ps

package mme_pkg;

  // field widths of the channels
  localparam int OP_W      = 2;
  localparam int IDX_W     = 4;
  localparam int VAL_W     = 16;
  localparam int SIZE_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int RES_W     = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE_LEFT  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_RIGHT = 2'd1;
  localparam logic [OP_W-1:0] OP_REQUEST     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COLS = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic term_valid;
  } mac_ctl_t;

endpackage

// ===== hw/rtl/mme_req_if.sv =====
// request channel: element writes and product requests
// depends on mme_pkg
`timescale 1ns / 1ps

interface mme_req_if;
  logic                                valid;
  logic                                ready;
  logic [mme_pkg::OP_W-1:0]            operation;
  logic [mme_pkg::IDX_W-1:0]           row_index;
  logic [mme_pkg::IDX_W-1:0]           col_index;
  logic signed [mme_pkg::VAL_W-1:0]    element_value;

  modport source (output valid, operation, row_index, col_index, element_value,
                  input ready);
  modport sink (input valid, operation, row_index, col_index, element_value,
                output ready);
endinterface

// ===== hw/rtl/mme_rsp_if.sv =====
// result channel: product value and status
// depends on mme_pkg
`timescale 1ns / 1ps

interface mme_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [mme_pkg::RES_W-1:0] product_value;
  logic                             status;

  modport source (output valid, product_value, status, input ready);
  modport sink (input valid, product_value, status, output ready);
endinterface

// ===== hw/rtl/mme_cfg_if.sv =====
// configuration write channel: register index and write data
// depends on mme_pkg
`timescale 1ns / 1ps

interface mme_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mme_pkg::CFG_IDX_W-1:0]   index;
  logic [mme_pkg::SIZE_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mme_store.sv =====
// single-port-write, single-port-read matrix element memory
// registered read data; no dependencies
`timescale 1ns / 1ps

module mme_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mme_mac.sv =====
// shared multiply-accumulate unit with 32-bit saturation of the sum
// depends on mme_pkg
`timescale 1ns / 1ps

module mme_mac #(
  parameter int OPERAND_BITS = 16,
  parameter int TERM_BITS    = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mme_pkg::mac_ctl_t                ctl,
  input  logic signed [OPERAND_BITS-1:0]   a,
  input  logic signed [OPERAND_BITS-1:0]   b,
  output logic                             busy,
  output logic signed [mme_pkg::RES_W-1:0] sum
);

  localparam int PROD_W = 2 * OPERAND_BITS;
  localparam int ACC_RAW_W = PROD_W + TERM_BITS;
  localparam int ACC_W = (ACC_RAW_W > mme_pkg::RES_W) ? ACC_RAW_W : mme_pkg::RES_W + 1;
  localparam logic [mme_pkg::RES_W-1:0] SAT_POS = {1'b0, {(mme_pkg::RES_W-1){1'b1}}};
  localparam logic [mme_pkg::RES_W-1:0] SAT_NEG = {1'b1, {(mme_pkg::RES_W-1){1'b0}}};

  logic                     prod_vld;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-mme_pkg::RES_W:0] acc_top;
  logic                     fits;

  // product stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctl.term_valid;
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (ctl.term_valid) begin
      prod <= a * b;
    end
  end

  // exact accumulator, cleared at the start of each request
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // saturate to 32 bits when the upper bits are not a pure sign extension
  assign acc_top = acc[ACC_W-1:mme_pkg::RES_W-1];
  assign fits    = (&acc_top) || !(|acc_top);
  assign sum     = fits ? acc[mme_pkg::RES_W-1:0] : (acc[ACC_W-1] ? SAT_NEG : SAT_POS);
  assign busy    = prod_vld;

endmodule

// ===== hw/rtl/matrix_multiply_engine.sv =====
// matrix multiply engine top level: sequencer, configuration registers,
// left and right element stores and the shared multiply-accumulate unit
// depends on mme_pkg, mme_req_if, mme_rsp_if, mme_cfg_if, mme_store, mme_mac, matrix_multiply_engine_assert.svh
//
// channel  modport  payload                                       role
// req      sink     operation, row_index, col_index, element_value writes and requests
// rsp      source   product_value, status                         results
// cfg      sink     index, data                                   size registers
//
// an element write that is in range returns nothing
// a range error or bad operation returns a range result via the result and output registers
// a product request is summed one term per cycle
// through the single multiply-accumulate unit fed by the two store read ports
// req is held off while a request is in flight; a result waiting on rsp does
// not block the next transfer; reset is synchronous and leaves both stores undefined
`timescale 1ns / 1ps
`include "matrix_multiply_engine_assert.svh"

module matrix_multiply_engine #(
  parameter int MAX_DIM      = 16,
  parameter int OPERAND_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  mme_req_if.sink    req,
  mme_rsp_if.source  rsp,
  mme_cfg_if.sink    cfg
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int SZ_W    = (DIM_W > mme_pkg::SIZE_W) ? DIM_W : mme_pkg::SIZE_W;
  localparam logic [SZ_W-1:0] MAX_SZ = SZ_W'(MAX_DIM);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]                   state;
  logic [SZ_W-1:0]              k;
  logic                         rd_vld;
  logic [mme_pkg::SIZE_W-1:0]   left_rows;
  logic [mme_pkg::SIZE_W-1:0]   inner_size;
  logic [mme_pkg::SIZE_W-1:0]   right_cols;
  logic [mme_pkg::IDX_W-1:0]    req_row;
  logic [mme_pkg::IDX_W-1:0]    req_col;
  logic [mme_pkg::RES_W-1:0]    res_value;
  logic                         res_status;
  logic                         rsp_valid;
  logic [mme_pkg::RES_W-1:0]    rsp_value;
  logic                         rsp_status;

  logic [SZ_W-1:0]              nl;
  logic [SZ_W-1:0]              nk;
  logic [SZ_W-1:0]              nr;
  logic [SZ_W-1:0]              row_x;
  logic [SZ_W-1:0]              col_x;
  logic                         left_ok;
  logic                         right_ok;
  logic                         prod_ok;
  logic                         item_err;
  logic                         req_fire;
  logic                         start_req;
  logic                         zero_len;
  logic                         sum_done;
  logic                         out_load;
  logic                         left_we;
  logic                         right_we;
  logic [AW-1:0]                waddr;
  logic [AW-1:0]                left_raddr;
  logic [AW-1:0]                right_raddr;
  logic signed [OPERAND_BITS-1:0] wr_value;
  logic [OPERAND_BITS-1:0]      left_rdata;
  logic [OPERAND_BITS-1:0]      right_rdata;
  mme_pkg::mac_ctl_t            mac_ctl;
  logic                         mac_busy;
  logic signed [mme_pkg::RES_W-1:0] mac_sum;

  // row-major element address
  function automatic logic [AW-1:0] elem_addr(input logic [SZ_W-1:0] r,
                                              input logic [SZ_W-1:0] c);
    elem_addr = AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  // effective sizes, clamped to the store dimension
  assign nl = (SZ_W'(left_rows) > MAX_SZ) ? MAX_SZ : SZ_W'(left_rows);
  assign nk = (SZ_W'(inner_size) > MAX_SZ) ? MAX_SZ : SZ_W'(inner_size);
  assign nr = (SZ_W'(right_cols) > MAX_SZ) ? MAX_SZ : SZ_W'(right_cols);

  // range checks on the incoming item
  assign row_x    = SZ_W'(req.row_index);
  assign col_x    = SZ_W'(req.col_index);
  assign left_ok  = (row_x < nl) && (col_x < nk);
  assign right_ok = (row_x < nk) && (col_x < nr);
  assign prod_ok  = (row_x < nl) && (col_x < nr);

  always_comb begin
    case (req.operation)
      mme_pkg::OP_WRITE_LEFT:  item_err = !left_ok;
      mme_pkg::OP_WRITE_RIGHT: item_err = !right_ok;
      mme_pkg::OP_REQUEST:     item_err = !prod_ok;
      default:                 item_err = 1'b1;
    endcase
  end

  // handshake and sequencer events
  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign start_req = req_fire && (req.operation == mme_pkg::OP_REQUEST) && prod_ok;
  assign zero_len  = (nk == '0);
  assign sum_done  = (state == ST_DRAIN) && !rd_vld && !mac_busy;
  assign out_load  = (state == ST_FINISH) && (!rsp_valid || rsp.ready);

  // element writes
  assign left_we  = req_fire && (req.operation == mme_pkg::OP_WRITE_LEFT) && left_ok;
  assign right_we = req_fire && (req.operation == mme_pkg::OP_WRITE_RIGHT) && right_ok;
  assign waddr    = elem_addr(row_x, col_x);
  assign wr_value = OPERAND_BITS'(req.element_value);

  // dot-product read addresses
  assign left_raddr  = elem_addr(SZ_W'(req_row), k);
  assign right_raddr = elem_addr(k, SZ_W'(req_col));

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      k          <= '0;
      rd_vld     <= 1'b0;
      rsp_valid  <= 1'b0;
      left_rows  <= mme_pkg::SIZE_RESET;
      inner_size <= mme_pkg::SIZE_RESET;
      right_cols <= mme_pkg::SIZE_RESET;
    end else begin
      // configuration writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          mme_pkg::REG_LEFT_ROWS:  left_rows  <= cfg.data;
          mme_pkg::REG_INNER_SIZE: inner_size <= cfg.data;
          mme_pkg::REG_RIGHT_COLS: right_cols <= cfg.data;
          default: ;
        endcase
      end

      rd_vld <= (state == ST_RUN);

      // output register
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req_fire && item_err) begin
            state <= ST_FINISH;
          end else if (start_req) begin
            k     <= '0;
            state <= zero_len ? ST_FINISH : ST_RUN;
          end
        end
        ST_RUN: begin
          if (k == nk - SZ_W'(1)) begin
            state <= ST_DRAIN;
          end else begin
            k <= k + SZ_W'(1);
          end
        end
        ST_DRAIN: begin
          if (sum_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start_req) begin
      req_row <= req.row_index;
      req_col <= req.col_index;
    end
    if (req_fire && item_err) begin
      res_value  <= '0;
      res_status <= mme_pkg::STATUS_RANGE;
    end else if (start_req && zero_len) begin
      res_value  <= '0;
      res_status <= mme_pkg::STATUS_OK;
    end else if (sum_done) begin
      res_value  <= mac_sum;
      res_status <= mme_pkg::STATUS_OK;
    end
    if (out_load) begin
      rsp_value  <= res_value;
      rsp_status <= res_status;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.product_value = rsp_value;
  assign rsp.status        = rsp_status;
  assign cfg.ready         = 1'b1;

  // operand stores
  mme_store #(
    .DEPTH (DEPTH),
    .WIDTH (OPERAND_BITS)
  ) u_left_store (
    .clk   (clk),
    .we    (left_we),
    .waddr (waddr),
    .wdata (wr_value),
    .raddr (left_raddr),
    .rdata (left_rdata)
  );

  mme_store #(
    .DEPTH (DEPTH),
    .WIDTH (OPERAND_BITS)
  ) u_right_store (
    .clk   (clk),
    .we    (right_we),
    .waddr (waddr),
    .wdata (wr_value),
    .raddr (right_raddr),
    .rdata (right_rdata)
  );

  // shared multiply-accumulate unit
  assign mac_ctl.clear      = start_req;
  assign mac_ctl.term_valid = rd_vld;

  mme_mac #(
    .OPERAND_BITS (OPERAND_BITS),
    .TERM_BITS    (SZ_W)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .a    (left_rdata),
    .b    (right_rdata),
    .busy (mac_busy),
    .sum  (mac_sum)
  );

  // checks on the sequencer
  `MME_ASSERT_IMP(a_no_write_busy, clk, rst, state != ST_IDLE, !left_we && !right_we)
  `MME_ASSERT_IMP(a_read_from_run, clk, rst, rd_vld, $past(state) == ST_RUN)
  `MME_ASSERT_IMP(a_k_bound, clk, rst, state == ST_RUN, k < nk)
  `MME_ASSERT_IMP(a_out_from_finish, clk, rst, $rose(rsp_valid), $past(state) == ST_FINISH)
  `MME_ASSERT_NXT(a_run_continues, clk, rst, state == ST_RUN && k != nk - SZ_W'(1), state == ST_RUN)

endmodule
